// ===== rtl/core/hfd_pkg.sv =====
// Shared types and constants of the handshake frame deframer.
`default_nettype none

package hfd_pkg;

	// Header layout: byte count and positions of the length fields.
	localparam int HDR_BYTES    = 18;
	localparam int NAME_LEN_POS = 12;
	localparam int BODY_LEN_POS = 14;
	localparam int HDR_IDX_W    = 5;

	// Result kinds.
	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_BODY = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	// Frame status codes.
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
	localparam logic [1:0] ST_BAD_LENGTH  = 2'd2;
	localparam logic [1:0] ST_BAD_VERSION = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAGIC    = 2'd0;
	localparam logic [1:0] CFG_VERSION  = 2'd1;
	localparam logic [1:0] CFG_CAPACITY = 2'd2;

	// Configuration register values as seen by the parser.
	typedef struct packed {
		logic [31:0] magic_word;
		logic [7:0]  expected_version;
		logic [8:0]  payload_capacity;
	} hfd_cfg_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [1:0]  status;
		logic [7:0]  version;
		logic [7:0]  operation;
		logic [15:0] flags;
		logic [15:0] algorithm;
		logic [15:0] result_code;
		logic [15:0] name_length;
		logic [31:0] body_length;
	} hfd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hfd_in_stage.sv =====
// Input register stage of the handshake frame deframer.
`default_nettype none

module hfd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       out_free,
	output logic            step,
	output logic [7:0]      byte_s1
);

	logic valid_s1;

	// The stage empties whenever the result side can take a step.
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Valid flag of the held byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The byte itself is loaded on each transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/hfd_parser.sv =====
// Frame parser: header store, phase tracking, checks and result forming.
`default_nettype none

module hfd_parser #(
	parameter int NAME_LIMIT    = 64,
	parameter int PAYLOAD_LIMIT = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       byte_s1,
	input  wire hfd_pkg::hfd_cfg_t cfg,
	output logic                  res_valid,
	output hfd_pkg::hfd_result_t  res
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_NAME   = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	localparam logic [15:0] NameLimitW    = 16'(NAME_LIMIT);
	localparam logic [31:0] PayloadLimitW = 32'(PAYLOAD_LIMIT);
	localparam logic [hfd_pkg::HDR_IDX_W-1:0] LastIdx =
		hfd_pkg::HDR_IDX_W'(hfd_pkg::HDR_BYTES - 1);
	localparam logic [hfd_pkg::HDR_IDX_W-1:0] HdrBytesW =
		hfd_pkg::HDR_IDX_W'(hfd_pkg::HDR_BYTES);

	logic [1:0]                      phase_q, phase_d;
	logic [hfd_pkg::HDR_IDX_W-1:0]   idx_q, idx_d, idx_eff;
	logic [31:0]                     left_q, left_d, left_dec;
	logic [7:0]                      store_q [hfd_pkg::HDR_BYTES];
	logic [7:0]                      hv [hfd_pkg::HDR_BYTES];
	logic                            in_header;
	logic [31:0]                     magic_rx;
	logic [15:0]                     hdr_nlen;
	logic [31:0]                     hdr_blen;
	logic [31:0]                     body_max;
	logic [1:0]                      ver_status;
	logic [1:0]                      kind_c;
	logic [7:0]                      data_c;
	logic                            end_c;
	logic [1:0]                      status_c;

	assign in_header = !(phase_q == PH_NAME || phase_q == PH_BODY);
	assign idx_eff   = (idx_q >= HdrBytesW) ? '0 : idx_q;

	// Header view: the byte being taken stands in for the last stored byte.
	always_comb begin
		for (int i = 0; i < hfd_pkg::HDR_BYTES; i++) begin
			hv[i] = store_q[i];
		end
		if (in_header) begin
			hv[hfd_pkg::HDR_BYTES-1] = byte_s1;
		end
	end

	// Header fields, big-endian.
	assign magic_rx = {hv[0], hv[1], hv[2], hv[3]};
	assign hdr_nlen = {hv[hfd_pkg::NAME_LEN_POS], hv[hfd_pkg::NAME_LEN_POS+1]};
	assign hdr_blen = {hv[hfd_pkg::BODY_LEN_POS], hv[hfd_pkg::BODY_LEN_POS+1],
	                   hv[hfd_pkg::BODY_LEN_POS+2], hv[hfd_pkg::BODY_LEN_POS+3]};

	// Body limit is the lesser of the fixed limit and the capacity register.
	assign body_max = ({23'b0, cfg.payload_capacity} < PayloadLimitW) ?
	                  {23'b0, cfg.payload_capacity} : PayloadLimitW;

	assign ver_status = (hv[4] != cfg.expected_version) ? hfd_pkg::ST_BAD_VERSION
	                                                    : hfd_pkg::ST_OK;
	assign left_dec   = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;

	// Next state and result of one step.
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		left_d    = left_q;
		res_valid = 1'b0;
		kind_c    = hfd_pkg::KIND_NONE;
		data_c    = 8'd0;
		end_c     = 1'b0;
		status_c  = hfd_pkg::ST_OK;
		case (phase_q)
			PH_NAME, PH_BODY: begin
				res_valid = 1'b1;
				kind_c    = (phase_q == PH_NAME) ? hfd_pkg::KIND_NAME : hfd_pkg::KIND_BODY;
				data_c    = byte_s1;
				left_d    = left_dec;
				if (left_dec == 32'd0) begin
					if (phase_q == PH_NAME && hdr_blen != 32'd0) begin
						phase_d = PH_BODY;
						left_d  = hdr_blen;
					end else begin
						phase_d  = PH_HEADER;
						idx_d    = '0;
						end_c    = 1'b1;
						status_c = ver_status;
					end
				end
			end
			default: begin
				phase_d = PH_HEADER;
				idx_d   = idx_eff + 1'b1;
				if (idx_eff == LastIdx) begin
					idx_d = '0;
					if (magic_rx != cfg.magic_word) begin
						res_valid = 1'b1;
						end_c     = 1'b1;
						status_c  = hfd_pkg::ST_BAD_MAGIC;
					end else if (hdr_nlen > NameLimitW || hdr_blen > body_max) begin
						res_valid = 1'b1;
						end_c     = 1'b1;
						status_c  = hfd_pkg::ST_BAD_LENGTH;
					end else if (hdr_nlen != 16'd0) begin
						phase_d = PH_NAME;
						left_d  = {16'b0, hdr_nlen};
					end else if (hdr_blen != 32'd0) begin
						phase_d = PH_BODY;
						left_d  = hdr_blen;
					end else begin
						res_valid = 1'b1;
						end_c     = 1'b1;
						status_c  = ver_status;
					end
				end
			end
		endcase
	end

	// Result item; header fields appear only on a frame end.
	always_comb begin
		res           = '0;
		res.kind      = kind_c;
		res.data_byte = data_c;
		res.frame_end = end_c;
		if (end_c) begin
			res.status      = status_c;
			res.version     = hv[4];
			res.operation   = hv[5];
			res.flags       = {hv[6], hv[7]};
			res.algorithm   = {hv[8], hv[9]};
			res.result_code = {hv[10], hv[11]};
			res.name_length = hdr_nlen;
			res.body_length = hdr_blen;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			left_q  <= 32'd0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			left_q  <= left_d;
		end
	end

	// Header byte store, written only while collecting a header.
	always_ff @(posedge clk) begin
		if (step && in_header) begin
			for (int i = 0; i < hfd_pkg::HDR_BYTES; i++) begin
				if (idx_eff == hfd_pkg::HDR_IDX_W'(i)) begin
					store_q[i] <= byte_s1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/hfd_out_stage.sv =====
// Output result register of the handshake frame deframer.
`default_nettype none

module hfd_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 res_valid,
	input  wire hfd_pkg::hfd_result_t res,
	output logic                      out_free,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output hfd_pkg::hfd_result_t      res_q
);

	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Valid flag: refilled or emptied whenever the register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	// Payload is loaded only when a new result arrives.
	always_ff @(posedge clk) begin
		if (out_free && step && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/handshake_frame_deframer_core.sv =====
// Top level of the handshake frame deframer: configuration registers and stages.
//
// Usage: one received byte is offered per transfer on in_valid/in_ready
// (rx_byte). Frames carry an 18-byte big-endian header followed by name and
// body bytes. Each name or body byte leaves as one result on out_valid/out_ready,
// tagged by kind; the last result of a frame, or a header error report, has
// frame_end set and carries the status and the header fields.
// Header bytes before the last give no result.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, and writes should be made while idle.
// Each byte passes the input register, which takes it on its transfer, and then
// the result register, which loads its result once that register is free.
// Throughput: one byte per cycle while the receiver keeps taking results.
// Reset clears the stage valid flags and the parser to header collection,
// and loads the configuration registers with their reset values.
// When the receiver stalls, the result register holds its item and one more
// byte waits in the input register; in_ready then drops until the result moves.
`default_nettype none

module handshake_frame_deframer_core #(
	parameter int NAME_LIMIT    = 64,
	parameter int PAYLOAD_LIMIT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic             frame_end,
	output logic [1:0]       status,
	output logic [7:0]       version,
	output logic [7:0]       operation,
	output logic [15:0]      flags,
	output logic [15:0]      algorithm,
	output logic [15:0]      result_code,
	output logic [15:0]      name_length,
	output logic [31:0]      body_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	hfd_pkg::hfd_cfg_t    cfg_q;
	hfd_pkg::hfd_result_t res, res_q;
	logic                 step;
	logic                 out_free;
	logic                 res_valid;
	logic [7:0]           byte_s1;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word       <= 32'd0;
			cfg_q.expected_version <= 8'd1;
			cfg_q.payload_capacity <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				hfd_pkg::CFG_MAGIC:    cfg_q.magic_word       <= cfg_data;
				hfd_pkg::CFG_VERSION:  cfg_q.expected_version <= cfg_data[7:0];
				hfd_pkg::CFG_CAPACITY: cfg_q.payload_capacity <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	hfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_free (out_free),
		.step     (step),
		.byte_s1  (byte_s1)
	);

	hfd_parser #(
		.NAME_LIMIT    (NAME_LIMIT),
		.PAYLOAD_LIMIT (PAYLOAD_LIMIT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	hfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	// Result fields onto their ports.
	assign kind        = res_q.kind;
	assign data_byte   = res_q.data_byte;
	assign frame_end   = res_q.frame_end;
	assign status      = res_q.status;
	assign version     = res_q.version;
	assign operation   = res_q.operation;
	assign flags       = res_q.flags;
	assign algorithm   = res_q.algorithm;
	assign result_code = res_q.result_code;
	assign name_length = res_q.name_length;
	assign body_length = res_q.body_length;

endmodule

`default_nettype wire

// ===== tb/hfd_checker.sv =====
// Checker of the handshake frame deframer: watches all channels, predicts results and compares.
module hfd_checker #(
	parameter int NAME_LIMIT    = 64,
	parameter int PAYLOAD_LIMIT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	input  wire logic [1:0]  status,
	input  wire logic [7:0]  version,
	input  wire logic [7:0]  operation,
	input  wire logic [15:0] flags,
	input  wire logic [15:0] algorithm,
	input  wire logic [15:0] result_code,
	input  wire logic [15:0] name_length,
	input  wire logic [31:0] body_length,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output logic             aligned
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NAME   = 2'd1,
		PH_BODY   = 2'd2
	} parse_phase_t;

	// Shadow copy of the registers and of the parser state.
	hfd_pkg::hfd_cfg_t     regs;
	parse_phase_t          phase;
	logic [4:0]            hdr_idx;
	logic [7:0]            hdr_store [hfd_pkg::HDR_BYTES];
	logic [31:0]           bytes_left;

	// Results predicted but not yet seen on the output channel, oldest first.
	hfd_pkg::hfd_result_t  due_results [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		aligned    = 1'b1;
	end

	function automatic logic [15:0] hdr16(input int pos);
		return {hdr_store[pos], hdr_store[pos + 1]};
	endfunction

	function automatic logic [31:0] hdr32(input int pos);
		return {hdr16(pos), hdr16(pos + 2)};
	endfunction

	// Header fields and status are only carried by a closing result.
	function automatic hfd_pkg::hfd_result_t make_result(input logic [1:0] k,
			input logic [7:0] d, input logic last, input logic [1:0] st);
		hfd_pkg::hfd_result_t r;
		r           = '0;
		r.kind      = k;
		r.data_byte = d;
		r.frame_end = last;
		if (last) begin
			r.status      = st;
			r.version     = hdr_store[4];
			r.operation   = hdr_store[5];
			r.flags       = hdr16(6);
			r.algorithm   = hdr16(8);
			r.result_code = hdr16(10);
			r.name_length = hdr16(hfd_pkg::NAME_LEN_POS);
			r.body_length = hdr32(hfd_pkg::BODY_LEN_POS);
		end
		return r;
	endfunction

	function automatic logic [1:0] close_status();
		return (hdr_store[4] != regs.expected_version) ? hfd_pkg::ST_BAD_VERSION
		                                               : hfd_pkg::ST_OK;
	endfunction

	// Advances the parser by one byte; returns 1 when the byte yields a result.
	function automatic bit parse_byte(input logic [7:0] b,
			output hfd_pkg::hfd_result_t r);
		logic [1:0]  k;
		logic [15:0] nlen;
		logic [31:0] blen;
		logic [31:0] bmax;
		r = '0;

		// Name and body bytes pass straight through.
		if (phase == PH_NAME || phase == PH_BODY) begin
			k = (phase == PH_NAME) ? hfd_pkg::KIND_NAME : hfd_pkg::KIND_BODY;
			if (bytes_left != 0)
				bytes_left--;
			if (bytes_left != 0) begin
				r = make_result(k, b, 1'b0, hfd_pkg::ST_OK);
				return 1'b1;
			end
			if (phase == PH_NAME && hdr32(hfd_pkg::BODY_LEN_POS) != 0) begin
				phase      = PH_BODY;
				bytes_left = hdr32(hfd_pkg::BODY_LEN_POS);
				r = make_result(k, b, 1'b0, hfd_pkg::ST_OK);
				return 1'b1;
			end
			phase   = PH_HEADER;
			hdr_idx = '0;
			r = make_result(k, b, 1'b1, close_status());
			return 1'b1;
		end

		// Header collection; nothing comes out before the last header byte.
		phase = PH_HEADER;
		if (hdr_idx >= hfd_pkg::HDR_BYTES)
			hdr_idx = '0;
		hdr_store[hdr_idx] = b;
		hdr_idx++;
		if (hdr_idx < hfd_pkg::HDR_BYTES)
			return 1'b0;
		hdr_idx = '0;

		nlen = hdr16(hfd_pkg::NAME_LEN_POS);
		blen = hdr32(hfd_pkg::BODY_LEN_POS);
		bmax = (regs.payload_capacity < PAYLOAD_LIMIT) ? 32'(regs.payload_capacity)
		                                               : 32'(PAYLOAD_LIMIT);
		if (hdr32(0) != regs.magic_word) begin
			r = make_result(hfd_pkg::KIND_NONE, 8'd0, 1'b1, hfd_pkg::ST_BAD_MAGIC);
			return 1'b1;
		end
		if (nlen > NAME_LIMIT || blen > bmax) begin
			r = make_result(hfd_pkg::KIND_NONE, 8'd0, 1'b1, hfd_pkg::ST_BAD_LENGTH);
			return 1'b1;
		end
		if (nlen != 0) begin
			phase      = PH_NAME;
			bytes_left = 32'(nlen);
			return 1'b0;
		end
		if (blen != 0) begin
			phase      = PH_BODY;
			bytes_left = blen;
			return 1'b0;
		end
		r = make_result(hfd_pkg::KIND_NONE, 8'd0, 1'b1, close_status());
		return 1'b1;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %0h, actual %0h", fname, want_v, got_v);
			fail_count++;
		end
	endtask

	// Sample every transfer at the clock edge and keep the prediction in step.
	always @(posedge clk or negedge arst_n) begin : monitor
		hfd_pkg::hfd_result_t want;
		if (!arst_n) begin
			regs.magic_word       = 32'd0;
			regs.expected_version = 8'd1;
			regs.payload_capacity = 9'd256;
			phase      = PH_HEADER;
			hdr_idx    = '0;
			bytes_left = '0;
			for (int i = 0; i < hfd_pkg::HDR_BYTES; i++)
				hdr_store[i] = 8'd0;
			due_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hfd_pkg::CFG_MAGIC:    regs.magic_word       = cfg_data;
					hfd_pkg::CFG_VERSION:  regs.expected_version = cfg_data[7:0];
					hfd_pkg::CFG_CAPACITY: regs.payload_capacity = cfg_data[8:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				if (parse_byte(rx_byte, want))
					due_results.push_back(want);
			end

			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d, data_byte %0h, frame_end %0d",
						kind, data_byte, frame_end);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
					check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
					check_field("status", 32'(want.status), 32'(status));
					check_field("version", 32'(want.version), 32'(version));
					check_field("operation", 32'(want.operation), 32'(operation));
					check_field("flags", 32'(want.flags), 32'(flags));
					check_field("algorithm", 32'(want.algorithm), 32'(algorithm));
					check_field("result_code", 32'(want.result_code), 32'(result_code));
					check_field("name_length", 32'(want.name_length), 32'(name_length));
					check_field("body_length", want.body_length, body_length);
				end
			end
		end
		pending = due_results.size();
		aligned = (phase == PH_HEADER) && (hdr_idx == '0);
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the deframer testbench: clock, reset, frame stimulus, receiver stalls and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_LIMIT    = 64;
	localparam int PAYLOAD_LIMIT = 256;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int ITEM_TARGET   = 1150;
	localparam int FORCED_HOLD_AT = 600;
	localparam int FORCED_HOLD_LEN = 200;

	// One frame header in wire order, first byte most significant.
	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  version;
		logic [7:0]  operation;
		logic [15:0] flags;
		logic [15:0] algorithm;
		logic [15:0] result_code;
		logic [15:0] name_length;
		logic [31:0] body_length;
	} frame_hdr_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'd0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = hfd_pkg::CFG_MAGIC;
	logic [31:0] cfg_data  = 32'd0;

	logic        in_ready;
	logic        out_valid;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic [1:0]  status;
	logic [7:0]  version;
	logic [7:0]  operation;
	logic [15:0] flags;
	logic [15:0] algorithm;
	logic [15:0] result_code;
	logic [15:0] name_length;
	logic [31:0] body_length;
	logic        cfg_ready;

	int          fail_count;
	int          pending;
	logic        aligned;

	int          cycle_count = 0;

	// Sender pacing and the register values currently in force.
	bit          offering   = 1'b0;
	int          burst_left = 0;
	int          bytes_sent = 0;
	logic [31:0] cur_magic;
	logic [7:0]  cur_version;
	logic [8:0]  cur_capacity;

	// Receiver stall pattern.
	int          hold_left   = 0;
	int          stall_mode  = 0;
	int          mode_left   = 0;
	bit          forced_done = 1'b0;

	handshake_frame_deframer_core #(
		.NAME_LIMIT   (NAME_LIMIT),
		.PAYLOAD_LIMIT(PAYLOAD_LIMIT)
	) u_dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .rx_byte,
		.out_valid, .out_ready,
		.kind, .data_byte, .frame_end, .status, .version, .operation,
		.flags, .algorithm, .result_code, .name_length, .body_length,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	hfd_checker #(
		.NAME_LIMIT   (NAME_LIMIT),
		.PAYLOAD_LIMIT(PAYLOAD_LIMIT)
	) u_checker (
		.clk, .arst_n,
		.in_valid, .in_ready, .rx_byte,
		.out_valid, .out_ready,
		.kind, .data_byte, .frame_end, .status, .version, .operation,
		.flags, .algorithm, .result_code, .name_length, .body_length,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending, .aligned
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("handshake_frame_deframer_core regression: fail");
			$finish;
		end
	end

	// Receiver: changing stall patterns, random long hold-offs and one forced hold-off
	// that lets the block fill up while the sender keeps offering.
	always @(posedge clk) begin : receiver
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!forced_done && offering && cycle_count >= FORCED_HOLD_AT) begin
			forced_done = 1'b1;
			hold_left   = FORCED_HOLD_LEN;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3999) == 0) begin
			hold_left = $urandom_range(150, 300);
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 300);
			end
			mode_left--;
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (cycle_count % 3 != 0);
			endcase
		end
	end

	function automatic int body_max();
		return (cur_capacity < PAYLOAD_LIMIT) ? int'(cur_capacity) : PAYLOAD_LIMIT;
	endfunction

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Offers one byte and waits for its transfer; gaps fall between bursts.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		rx_byte  <= b;
		in_valid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(0, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic stop_sending();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Writes all three registers in back-to-back transfers.
	task automatic write_settings(input logic [31:0] m, input logic [7:0] v,
			input logic [8:0] c);
		cfg_valid <= 1'b1;
		cfg_index <= hfd_pkg::CFG_MAGIC;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= hfd_pkg::CFG_VERSION;
		cfg_data  <= {24'd0, v};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= hfd_pkg::CFG_CAPACITY;
		cfg_data  <= {23'd0, c};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_magic    = m;
		cur_version  = v;
		cur_capacity = c;
	endtask

	// Feeds filler until the parser stands at the start of a header. The filler never
	// matches the first magic byte, so any header that it starts ends at once.
	task automatic realign();
		stop_sending();
		forever begin
			@(negedge clk);
			if (aligned)
				break;
			@(posedge clk);
			send_byte(~cur_magic[31:24]);
			stop_sending();
		end
		@(posedge clk);
	endtask

	// Brings the block to idle: aligned, no result outstanding, pipeline drained.
	task automatic settle();
		realign();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic frame_hdr_t random_header();
		frame_hdr_t h;
		h.magic       = cur_magic;
		h.version     = cur_version;
		h.operation   = 8'($urandom);
		h.flags       = 16'($urandom);
		h.algorithm   = 16'($urandom);
		h.result_code = 16'($urandom);
		h.name_length = 16'd0;
		h.body_length = 32'd0;
		return h;
	endfunction

	// Sends the first hdr_count header bytes, then data_count random data bytes.
	task automatic send_frame(input frame_hdr_t h, input int hdr_count, input int data_count);
		logic [143:0] flat;
		flat = h;
		for (int i = 0; i < hdr_count; i++)
			send_byte(flat[143 - 8 * i -: 8]);
		for (int i = 0; i < data_count; i++)
			send_byte(8'($urandom));
	endtask

	task automatic send_whole(input frame_hdr_t h);
		send_frame(h, hfd_pkg::HDR_BYTES, int'(h.name_length) + int'(h.body_length));
	endtask

	task automatic change_settings();
		logic [31:0] m;
		logic [7:0]  v;
		logic [8:0]  c;
		int          sel;
		sel = $urandom_range(0, 3);
		m = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom);
		sel = $urandom_range(0, 3);
		v = (sel == 0) ? 8'd0 : (sel == 1) ? 8'hFF : 8'($urandom);
		sel = $urandom_range(0, 7);
		case (sel)
			0:       c = 9'd0;
			1:       c = 9'd256;
			2:       c = 9'($urandom_range(0, 16));
			default: c = 9'($urandom_range(0, 256));
		endcase
		settle();
		write_settings(m, v, c);
	endtask

	// Stimulus: reset, directed frames, then random frames under changing settings.
	initial begin : stimulus
		frame_hdr_t h;
		int         pick;
		int         total;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames with the receive path at full payload size.
		write_settings(32'hC0DE_F00D, 8'h01, 9'd256);
		h = random_header();
		send_whole(h);
		h = random_header(); h.version = cur_version ^ 8'h80;
		send_whole(h);
		h = random_header(); h.name_length = 16'd1;
		send_whole(h);
		h = random_header(); h.body_length = 32'd1;
		send_whole(h);
		h = random_header(); h.name_length = 16'(NAME_LIMIT); h.body_length = 32'd3;
		send_whole(h);
		h = random_header(); h.name_length = 16'(NAME_LIMIT + 1);
		send_frame(h, hfd_pkg::HDR_BYTES, 0);
		h = random_header(); h.name_length = 16'hFFFF; h.body_length = 32'hFFFF_FFFF;
		send_frame(h, hfd_pkg::HDR_BYTES, 0);
		h = random_header();
		h.operation = 8'hFF; h.flags = 16'hFFFF; h.algorithm = 16'hFFFF;
		h.result_code = 16'hFFFF; h.body_length = 32'd256;
		send_whole(h);
		h = random_header();
		h.operation = 8'h00; h.flags = 16'h0000; h.algorithm = 16'h0000;
		h.result_code = 16'h0000; h.body_length = 32'd257;
		send_frame(h, hfd_pkg::HDR_BYTES, 0);
		h = random_header(); h.magic = cur_magic ^ 32'h8000_0000;
		send_frame(h, hfd_pkg::HDR_BYTES, 0);
		h = random_header(); h.magic = cur_magic ^ 32'h0000_0001; h.name_length = 16'd2;
		send_frame(h, hfd_pkg::HDR_BYTES, 0);
		h = random_header(); h.version = 8'h00; h.name_length = 16'd2; h.body_length = 32'd2;
		send_whole(h);
		for (int i = 0; i < 5; i++)
			send_byte(8'($urandom));
		realign();
		h = random_header(); h.name_length = 16'd4; h.body_length = 32'd4;
		send_frame(h, hfd_pkg::HDR_BYTES, 3);
		realign();

		// All-zero registers: only empty bodies fit.
		settle();
		write_settings(32'd0, 8'd0, 9'd0);
		h = random_header();
		send_whole(h);
		h = random_header(); h.body_length = 32'd1;
		send_frame(h, hfd_pkg::HDR_BYTES, 0);
		h = random_header(); h.name_length = 16'd3;
		send_whole(h);

		// All-ones magic and version, capacity just below the payload limit.
		settle();
		write_settings(32'hFFFF_FFFF, 8'hFF, 9'd255);
		h = random_header(); h.body_length = 32'd255;
		send_whole(h);
		h = random_header(); h.body_length = 32'd256;
		send_frame(h, hfd_pkg::HDR_BYTES, 0);

		settle();
		write_settings(32'h5A5A_A5A5, 8'h01, 9'd256);

		// Random part: mostly well-formed frames, the rest broken, noise or new settings.
		while (bytes_sent < ITEM_TARGET) begin
			h    = random_header();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				h.name_length = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
				h.body_length = $urandom_range(0, min_int(12, body_max()));
				if ($urandom_range(0, 9) == 0)
					h.version = cur_version ^ (8'd1 << $urandom_range(0, 7));
				send_whole(h);
			end else if (pick < 66) begin
				h.name_length = 16'($urandom_range(0, NAME_LIMIT));
				h.body_length = $urandom_range(0, body_max());
				send_whole(h);
			end else if (pick < 74) begin
				h.magic       = cur_magic ^ (32'd1 << $urandom_range(0, 31));
				h.name_length = 16'($urandom);
				h.body_length = $urandom;
				send_frame(h, hfd_pkg::HDR_BYTES, 0);
			end else if (pick < 82) begin
				if ($urandom_range(0, 1) == 0) begin
					h.name_length = 16'($urandom_range(NAME_LIMIT + 1, 65535));
					h.body_length = $urandom;
				end else begin
					h.name_length = 16'($urandom_range(0, NAME_LIMIT));
					h.body_length = ($urandom_range(0, 1) == 0)
						? 32'(body_max() + 1 + $urandom_range(0, 200))
						: (32'h8000_0000 | $urandom);
				end
				send_frame(h, hfd_pkg::HDR_BYTES, 0);
			end else if (pick < 89) begin
				// Cut short, either inside the header or inside the data.
				h.name_length = 16'($urandom_range(1, 8));
				h.body_length = $urandom_range(0, min_int(12, body_max()));
				total = int'(h.name_length) + int'(h.body_length);
				if ($urandom_range(0, 1) == 0)
					send_frame(h, $urandom_range(1, hfd_pkg::HDR_BYTES - 1), 0);
				else
					send_frame(h, hfd_pkg::HDR_BYTES, $urandom_range(0, total - 1));
				realign();
			end else if (pick < 96) begin
				total = $urandom_range(1, 30);
				for (int i = 0; i < total; i++)
					send_byte(8'($urandom));
				realign();
			end else begin
				change_settings();
			end
		end

		// Drain and give the verdict.
		stop_sending();
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("handshake_frame_deframer_core regression: pass");
		else
			$display("handshake_frame_deframer_core regression: fail");
		$finish;
	end

endmodule
